/* src/twms_pkg.sv */
package twms_pkg;

    localparam int WINDOW_SLOTS = 32;
    localparam int MODE_COUNT   = 16;
    localparam int TYPE_COUNT   = 16;
    localparam int SLOT_AW      = $clog2(WINDOW_SLOTS);

    // Item kinds carried on the input tuser bit.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Window kinds.
    localparam logic [1:0] KIND_EMPTY    = 2'd0;
    localparam logic [1:0] KIND_ABSOLUTE = 2'd1;
    localparam logic [1:0] KIND_DAY      = 2'd2;
    localparam logic [1:0] KIND_DAILY    = 2'd3;

    localparam int ODD_MINUTE_BIT = 7;
    localparam logic [2:0] WDAY_SUNDAY   = 3'd0;
    localparam logic [2:0] WDAY_SATURDAY = 3'd6;
    localparam logic [2:0] SUNDAY_MASK_BIT = 3'd6;

    // Priority reported for the default mode (-1 in nine bits).
    localparam logic signed [8:0] DEFAULT_PRIO = -9'sd1;

    typedef struct packed {
        logic [7:0] prio;
        logic [7:0] day_mask;
        logic [1:0] kind;
        logic [3:0] mode_num;
        logic [3:0] type_num;
    } t_info;

    typedef struct packed {
        logic [31:0] hi;
        logic [31:0] lo;
    } t_bounds;

    typedef struct packed {
        logic [3:0]  type_num;
        logic [31:0] epoch;
        logic [2:0]  wday;
        logic [10:0] minute;
    } t_query;

    typedef struct packed {
        logic             we;
        logic [SLOT_AW-1:0] waddr;
        logic             re;
        logic [SLOT_AW-1:0] raddr;
    } t_ram_ctl;

    typedef struct packed {
        logic       hit;
        logic [3:0] mode_num;
        logic [7:0] prio;
    } t_hit;

    typedef struct packed {
        logic signed [8:0] prio;
        logic              custom;
        logic [4:0]        mode_index;
    } t_result;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_DONE
    } t_state;

endpackage

/* src/twms_ram.sv */
module twms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/twms_match.sv */
module twms_match (
    input  logic             i_live,
    input  twms_pkg::t_info   i_info,
    input  twms_pkg::t_bounds i_bounds,
    input  twms_pkg::t_query  i_query,
    output twms_pkg::t_hit    o_hit
);

    logic [2:0]  day_sel;
    logic        day_ok;
    logic [31:0] minute_w;
    logic        tod_ok;
    logic        abs_ok;
    logic        active;
    logic        tag_ok;

    always_comb begin
        day_sel = (i_query.wday == twms_pkg::WDAY_SUNDAY) ? twms_pkg::SUNDAY_MASK_BIT
                                                         : i_query.wday - 3'd1;
        if (i_info.day_mask[twms_pkg::ODD_MINUTE_BIT]) begin
            day_ok = i_query.minute[0];
        end else if (i_query.wday > twms_pkg::WDAY_SATURDAY) begin
            day_ok = 1'b0;
        end else begin
            day_ok = i_info.day_mask[day_sel];
        end

        // A time-of-day range with start at or past its end wraps midnight.
        minute_w = 32'(i_query.minute);
        if (i_bounds.lo < i_bounds.hi) begin
            tod_ok = (minute_w >= i_bounds.lo) && (minute_w <= i_bounds.hi);
        end else begin
            tod_ok = (minute_w >= i_bounds.lo) || (minute_w <= i_bounds.hi);
        end
        abs_ok = (i_query.epoch >= i_bounds.lo) && (i_query.epoch <= i_bounds.hi);

        case (i_info.kind)
            twms_pkg::KIND_ABSOLUTE: active = abs_ok;
            twms_pkg::KIND_DAY:      active = day_ok && tod_ok;
            twms_pkg::KIND_DAILY:    active = tod_ok;
            default:                 active = 1'b0;
        endcase

        tag_ok = (i_info.type_num == i_query.type_num)
              && (int'(i_query.type_num) < twms_pkg::TYPE_COUNT)
              && (int'(i_info.mode_num) < twms_pkg::MODE_COUNT);

        o_hit.hit      = i_live && tag_ok && active;
        o_hit.mode_num = i_info.mode_num;
        o_hit.prio     = i_info.prio;
    end

endmodule

/* src/twms_seq.sv */
module twms_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_opcode,
    input  logic [4:0]                  i_slot,
    input  twms_pkg::t_query            i_query,
    output twms_pkg::t_query            o_query,
    output twms_pkg::t_ram_ctl          o_ram_ctl,
    output logic                        o_rd_live,
    input  twms_pkg::t_hit              i_hit,
    output twms_pkg::t_result           o_result,
    output logic                        o_out_valid,
    input  logic                        i_out_ready
);

    twms_pkg::t_state r_state, n_state;
    logic [twms_pkg::SLOT_AW-1:0] r_addr;
    logic [twms_pkg::WINDOW_SLOTS-1:0] r_valid;
    logic r_rd_vld;
    logic r_rd_live;
    twms_pkg::t_query r_query;
    logic r_found;
    logic [7:0] r_best_prio;
    logic [3:0] r_best_mode;
    logic r_out_valid;
    twms_pkg::t_result r_result;

    logic accept;
    logic wr_hit;
    logic last_addr;
    logic load_out;
    logic better;

    always_comb begin
        n_state = r_state;
        case (r_state)
            twms_pkg::ST_IDLE: begin
                if (accept && i_opcode == twms_pkg::OP_QUERY) begin
                    n_state = twms_pkg::ST_SCAN;
                end
            end
            twms_pkg::ST_SCAN: begin
                if (last_addr) begin
                    n_state = twms_pkg::ST_LAST;
                end
            end
            twms_pkg::ST_LAST: n_state = twms_pkg::ST_DONE;
            twms_pkg::ST_DONE: begin
                if (load_out) begin
                    n_state = twms_pkg::ST_IDLE;
                end
            end
            default: n_state = twms_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready      = (r_state == twms_pkg::ST_IDLE);
        accept          = i_in_valid && o_in_ready;
        wr_hit          = accept && (i_opcode == twms_pkg::OP_WRITE)
                       && (int'(i_slot) < twms_pkg::WINDOW_SLOTS);
        last_addr       = (r_addr == twms_pkg::SLOT_AW'(twms_pkg::WINDOW_SLOTS - 1));
        load_out        = (r_state == twms_pkg::ST_DONE) && (!r_out_valid || i_out_ready);
        o_ram_ctl.we    = wr_hit;
        o_ram_ctl.waddr = twms_pkg::SLOT_AW'(i_slot);
        o_ram_ctl.re    = (r_state == twms_pkg::ST_SCAN);
        o_ram_ctl.raddr = r_addr;
        better = !r_found || (i_hit.prio > r_best_prio)
              || ((i_hit.prio == r_best_prio) && (i_hit.mode_num < r_best_mode));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= twms_pkg::ST_IDLE;
            r_valid     <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
            r_found     <= 1'b0;
            r_addr      <= '0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= (r_state == twms_pkg::ST_SCAN);
            if (wr_hit) begin
                r_valid[twms_pkg::SLOT_AW'(i_slot)] <= 1'b1;
            end
            if (accept) begin
                r_addr  <= '0;
                r_found <= 1'b0;
            end else if (r_state == twms_pkg::ST_SCAN) begin
                r_addr <= r_addr + 1'b1;
            end
            if (r_rd_vld && i_hit.hit && better) begin
                r_found <= 1'b1;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_live <= r_valid[r_addr];
        if (accept) begin
            r_query <= i_query;
        end
        if (r_rd_vld && i_hit.hit && better) begin
            r_best_prio <= i_hit.prio;
            r_best_mode <= i_hit.mode_num;
        end
        if (load_out) begin
            r_result.custom <= r_found;
            if (r_found) begin
                r_result.mode_index <= 5'(r_best_mode) + 5'd1;
                r_result.prio       <= $signed({1'b0, r_best_prio});
            end else begin
                r_result.mode_index <= '0;
                r_result.prio       <= twms_pkg::DEFAULT_PRIO;
            end
        end
    end

    assign o_query     = r_query;
    assign o_rd_live   = r_rd_live;
    assign o_result    = r_result;
    assign o_out_valid = r_out_valid;

endmodule

/* src/time_window_mode_selector.sv */
// Time-window mode selector. Write words (tuser low) load one slot of a 32-entry window
// table. Query words (tuser high) walk the whole table through one read port of the
// table memories, one slot per cycle, keep the best active window of the queried type
// (highest priority, then lowest mode number), and return one result word: a query is
// accepted, each slot is read in turn, the last slot is evaluated and the result is loaded
// into the output register once it is free or being drained; no new word is taken until
// then. The result sits in an output register, so the next word is accepted while it
// waits. Slot occupancy is kept in flip-flops cleared by reset, so no clearing pass
// follows reset and the block is ready as soon as reset ends.
module time_window_mode_selector (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    // From bit 0 up: slot[4:0], type_number[8:5], mode_number[12:9],
    // window_kind[14:13], day_mask[22:15], window_start[54:23], window_end[86:55],
    // priority_req[94:87], current_epoch[126:95], weekday[129:127],
    // minute_of_day[140:130], zero fill[143:141].
    input  logic [143:0]   s_axis_tdata,
    // opcode: 0 write, 1 query.
    input  logic           s_axis_tuser,
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    // From bit 0 up: mode_index[4:0], custom_matched[5], applied_priority[14:6],
    // zero fill[15].
    output logic [15:0]    m_axis_tdata
);

    twms_pkg::t_query   in_query;
    twms_pkg::t_query   cur_query;
    twms_pkg::t_ram_ctl ram_ctl;
    twms_pkg::t_info    wr_info;
    twms_pkg::t_bounds  wr_bounds;
    twms_pkg::t_info    rd_info;
    twms_pkg::t_bounds  rd_bounds;
    twms_pkg::t_hit     hit;
    twms_pkg::t_result  result;
    logic               rd_live;

    // Query fields share the input word with the write fields.
    assign in_query.type_num = s_axis_tdata[8:5];
    assign in_query.epoch    = s_axis_tdata[126:95];
    assign in_query.wday     = s_axis_tdata[129:127];
    assign in_query.minute   = s_axis_tdata[140:130];

    assign wr_info.type_num = s_axis_tdata[8:5];
    assign wr_info.mode_num = s_axis_tdata[12:9];
    assign wr_info.kind     = s_axis_tdata[14:13];
    assign wr_info.day_mask = s_axis_tdata[22:15];
    assign wr_info.prio     = s_axis_tdata[94:87];
    assign wr_bounds.lo     = s_axis_tdata[54:23];
    assign wr_bounds.hi     = s_axis_tdata[86:55];

    // Window descriptors: type, mode, kind, day mask and priority.
    twms_ram #(
        .WIDTH($bits(twms_pkg::t_info)),
        .DEPTH(twms_pkg::WINDOW_SLOTS)
    ) u_info_ram (
        .i_clk  (i_clk),
        .i_we   (ram_ctl.we),
        .i_waddr(ram_ctl.waddr),
        .i_wdata(wr_info),
        .i_re   (ram_ctl.re),
        .i_raddr(ram_ctl.raddr),
        .o_rdata(rd_info)
    );

    // Start and end bounds; read for every slot in a scan, written or not.
    twms_ram #(
        .WIDTH($bits(twms_pkg::t_bounds)),
        .DEPTH(twms_pkg::WINDOW_SLOTS)
    ) u_bounds_ram (
        .i_clk  (i_clk),
        .i_we   (ram_ctl.we),
        .i_waddr(ram_ctl.waddr),
        .i_wdata(wr_bounds),
        .i_re   (ram_ctl.re),
        .i_raddr(ram_ctl.raddr),
        .o_rdata(rd_bounds)
    );

    // Decides whether the slot just read is an active window of the queried type.
    twms_match u_match (
        .i_live  (rd_live),
        .i_info  (rd_info),
        .i_bounds(rd_bounds),
        .i_query (cur_query),
        .o_hit   (hit)
    );

    // Handshake, table scan sequencing, best-window tracking and the output register.
    twms_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_opcode   (s_axis_tuser),
        .i_slot     (s_axis_tdata[4:0]),
        .i_query    (in_query),
        .o_query    (cur_query),
        .o_ram_ctl  (ram_ctl),
        .o_rd_live  (rd_live),
        .i_hit      (hit),
        .o_result   (result),
        .o_out_valid(m_axis_tvalid),
        .i_out_ready(m_axis_tready)
    );

    assign m_axis_tdata = {1'b0, result.prio, result.custom, result.mode_index};

`ifndef ASSERT_OFF
    // A write word never produces a result word.
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == twms_pkg::OP_WRITE
         && !m_axis_tvalid) |=> !m_axis_tvalid)
        else $error("write word produced a result");

    // The table is busy scanning right after a query is taken.
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == twms_pkg::OP_QUERY)
        |=> !s_axis_tready)
        else $error("input accepted during a table scan");

    // A custom result carries a nonzero mode index and a nonnegative priority;
    // the default result carries index zero and priority -1.
    a_result_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[5]
            ? (m_axis_tdata[4:0] != 5'd0 && !m_axis_tdata[14])
            : (m_axis_tdata[4:0] == 5'd0 && m_axis_tdata[14:6] == 9'h1FF)))
        else $error("inconsistent result word");
`endif

endmodule

/* bench/mode_select_checker.sv */
`timescale 1ns / 100ps

// Watches both stream channels of the mode selector. It keeps its own copy of the
// window table and works out the answer to every accepted query. It then compares
// each returned word with the oldest answer still waiting.
module mode_select_checker
    import twms_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [143:0] i_s_tdata,
    input  logic         i_s_tuser,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [15:0]  i_m_tdata,
    output int           o_err_count,
    output int           o_pending
);

    // Input word layout, from the top bit down to bit 0.
    typedef struct packed {
        logic [2:0]  fill;
        logic [10:0] minute;
        logic [2:0]  wday;
        logic [31:0] epoch;
        logic [7:0]  prio;
        logic [31:0] hi;
        logic [31:0] lo;
        logic [7:0]  mask;
        logic [1:0]  kind;
        logic [3:0]  mode_num;
        logic [3:0]  type_num;
        logic [4:0]  slot;
    } t_in_word;

    t_info   table_info   [WINDOW_SLOTS];
    t_bounds table_bounds [WINDOW_SLOTS];
    t_result expected_modes[$];
    int      mismatch_total  = 0;
    int      pending_results = 0;

    assign o_err_count = mismatch_total;
    assign o_pending   = pending_results;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: %s got %0d, expected %0d", $time, what, got, want);
        mismatch_total++;
    endtask

    // Time-of-day range check. When start >= end the range wraps past midnight,
    // so equal bounds cover the whole day.
    function automatic logic tod_match(logic [31:0] now, logic [31:0] lo, logic [31:0] hi);
        if (lo < hi)
            return (now >= lo) && (now <= hi);
        return (now >= lo) || (now <= hi);
    endfunction

    // The odd-minute bit overrides the day bits. Weekday seven has no day bit.
    function automatic logic day_match(logic [7:0] mask, logic [2:0] wday, logic [10:0] minute);
        logic [2:0] bit_sel;
        if (mask[ODD_MINUTE_BIT])
            return minute[0];
        if (wday > WDAY_SATURDAY)
            return 1'b0;
        bit_sel = (wday == WDAY_SUNDAY) ? SUNDAY_MASK_BIT : wday - 3'd1;
        return mask[bit_sel];
    endfunction

    function automatic t_result select_mode(t_query q);
        int         best_prio;
        logic [3:0] best_mode;
        t_info      w;
        t_bounds    b;
        logic       active;
        t_result    r;
        best_prio = -1;
        best_mode = '0;
        if (int'(q.type_num) < TYPE_COUNT) begin
            for (int i = 0; i < WINDOW_SLOTS; i++) begin
                w = table_info[i];
                b = table_bounds[i];
                if (w.kind == KIND_EMPTY || w.type_num != q.type_num)
                    continue;
                if (int'(w.mode_num) >= MODE_COUNT)
                    continue;
                case (w.kind)
                    KIND_ABSOLUTE: active = (q.epoch >= b.lo) && (q.epoch <= b.hi);
                    KIND_DAY:      active = day_match(w.day_mask, q.wday, q.minute)
                                            && tod_match(32'(q.minute), b.lo, b.hi);
                    KIND_DAILY:    active = tod_match(32'(q.minute), b.lo, b.hi);
                    default:       active = 1'b0;
                endcase
                if (active && (int'(w.prio) > best_prio ||
                               (int'(w.prio) == best_prio && w.mode_num < best_mode))) begin
                    best_prio = int'(w.prio);
                    best_mode = w.mode_num;
                end
            end
        end
        if (best_prio >= 0) begin
            r.mode_index = 5'(best_mode) + 5'd1;
            r.custom     = 1'b1;
            r.prio       = 9'(best_prio);
        end else begin
            r.mode_index = '0;
            r.custom     = 1'b0;
            r.prio       = DEFAULT_PRIO;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_in_word w;
        t_query   q;
        t_result  got;
        t_result  want;
        if (!i_rst_n) begin
            for (int i = 0; i < WINDOW_SLOTS; i++) begin
                table_info[i]   = '0;
                table_bounds[i] = '0;
            end
            expected_modes.delete();
            pending_results = 0;
        end else begin
            // A result leaving now always belongs to an earlier query, so retire it first.
            if (i_m_tvalid && i_m_tready) begin
                got = t_result'(i_m_tdata[14:0]);
                if (expected_modes.size() == 0) begin
                    report_mismatch("result with no query waiting, mode_index",
                                    got.mode_index, -1);
                end else begin
                    want = expected_modes.pop_front();
                    pending_results = expected_modes.size();
                    if (got.mode_index != want.mode_index)
                        report_mismatch("mode_index", got.mode_index, want.mode_index);
                    if (got.custom != want.custom)
                        report_mismatch("custom_matched", got.custom, want.custom);
                    if (got.prio != want.prio)
                        report_mismatch("applied_priority", got.prio, want.prio);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                w = t_in_word'(i_s_tdata);
                if (i_s_tuser == OP_WRITE) begin
                    if (int'(w.slot) < WINDOW_SLOTS) begin
                        table_info[w.slot] = '{prio: w.prio, day_mask: w.mask,
                                               kind: w.kind, mode_num: w.mode_num,
                                               type_num: w.type_num};
                        table_bounds[w.slot] = '{hi: w.hi, lo: w.lo};
                    end
                end else begin
                    q = '{type_num: w.type_num, epoch: w.epoch,
                          wday: w.wday, minute: w.minute};
                    expected_modes.insert(expected_modes.size(), select_mode(q));
                    pending_results = expected_modes.size();
                end
            end
        end
    end

endmodule

/* bench/time_window_mode_selector_tb.sv */
`timescale 1ns / 100ps

// Stimulus and verdict for the time-window mode selector. Write words load the
// window table and query words ask for the active mode; the checker beside the
// block predicts every answer and counts mismatches. The sender moves words in
// bursts of random length separated by random gaps, and the receiver drops its
// ready on an independent run-length pattern.
module time_window_mode_selector_tb;
    import twms_pkg::*;

    logic         i_clk;
    logic         i_rst_n       = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [143:0] s_axis_tdata  = '0;
    logic         s_axis_tuser  = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [15:0]  m_axis_tdata;

    int mismatch_count;
    int results_due;

    // Sender burst state: words left in the current burst.
    int burst_left = 0;
    // Receiver pattern state: cycles left before the ready level is redrawn.
    int rx_hold    = 0;

    // Random part settings, redrawn every few hundred words.
    int          type_top;
    int          prio_top;
    logic [31:0] epoch_base;

    time_window_mode_selector DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    mode_select_checker checker_inst (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_axis_tvalid),
        .i_s_tready  (s_axis_tready),
        .i_s_tdata   (s_axis_tdata),
        .i_s_tuser   (s_axis_tuser),
        .i_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .i_m_tdata   (m_axis_tdata),
        .o_err_count (mismatch_count),
        .o_pending   (results_due)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: the ready level holds for a random run length, then
    // a new level is drawn, high twice as often as low.
    always @(posedge i_clk) begin
        if (rx_hold != 0) begin
            rx_hold <= rx_hold - 1;
        end else begin
            rx_hold       <= $urandom_range(0, 40);
            m_axis_tready <= ($urandom_range(0, 2) != 0);
        end
    end

    // Hard stop well past the slowest legal run: every word a query waiting out
    // the full table walk, the longest receiver stall and the longest sender gap.
    initial begin
        #7_000_000;
        $display("time_window_mode_selector_tb: errors");
        $finish;
    end

    // Packs the input fields in port order, slot in the lowest bits.
    function automatic logic [143:0] pack_word(
        logic [4:0] slot, logic [3:0] type_num, logic [3:0] mode_num, logic [1:0] kind,
        logic [7:0] mask, logic [31:0] lo, logic [31:0] hi, logic [7:0] prio,
        logic [31:0] epoch, logic [2:0] wday, logic [10:0] minute);
        return {3'b000, minute, wday, epoch, prio, hi, lo, mask, kind, mode_num,
                type_num, slot};
    endfunction

    // Drives one word and returns once it has been accepted. A new burst may
    // start with a gap; a zero gap keeps tvalid high across the burst boundary.
    task automatic send_word(input logic op, input logic [143:0] word);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= word;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        burst_left--;
    endtask

    // A write word carries random noise in the query fields.
    task automatic send_window(input logic [4:0] slot, input logic [3:0] type_num,
                               input logic [3:0] mode_num, input logic [1:0] kind,
                               input logic [7:0] mask, input logic [31:0] lo,
                               input logic [31:0] hi, input logic [7:0] prio);
        send_word(OP_WRITE, pack_word(slot, type_num, mode_num, kind, mask, lo, hi, prio,
                                      $urandom, 3'($urandom), 11'($urandom)));
    endtask

    // A query word carries random noise in the write fields.
    task automatic send_query(input logic [3:0] type_num, input logic [31:0] epoch,
                              input logic [2:0] wday, input logic [10:0] minute);
        send_word(OP_QUERY, pack_word(5'($urandom), type_num, 4'($urandom), 2'($urandom),
                                      8'($urandom), $urandom, $urandom, 8'($urandom),
                                      epoch, wday, minute));
    endtask

    // Time-of-day bounds: mostly a real minute, sometimes past the end of the
    // day, sometimes any 32-bit value.
    function automatic logic [31:0] pick_tod_bound();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 8)
            return $urandom_range(0, 1439);
        if (sel == 8)
            return $urandom_range(1440, 2047);
        return $urandom;
    endfunction

    function automatic logic [10:0] pick_minute();
        if ($urandom_range(0, 9) == 0)
            return 11'($urandom_range(1440, 2047));
        return 11'($urandom_range(0, 1439));
    endfunction

    // One random write: kinds evenly spread, absolute windows placed around
    // the current epoch base so that queries land inside them often.
    task automatic random_write();
        logic [1:0]  kind;
        logic [7:0]  mask;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] swap;
        kind = 2'($urandom);
        mask = {($urandom_range(0, 3) == 0), 7'($urandom)};
        if (kind == KIND_ABSOLUTE) begin
            if ($urandom_range(0, 9) == 0) begin
                lo = $urandom;
                hi = $urandom;
            end else begin
                lo = epoch_base + $urandom_range(0, 4000);
                hi = lo + $urandom_range(0, 4000);
            end
            // Now and then swap the bounds; an inverted range is never active.
            if ($urandom_range(0, 9) == 0) begin
                swap = lo;
                lo   = hi;
                hi   = swap;
            end
        end else begin
            lo = pick_tod_bound();
            hi = pick_tod_bound();
        end
        send_window(5'($urandom), 4'($urandom_range(0, type_top)), 4'($urandom), kind, mask,
                    lo, hi, 8'($urandom_range(0, prio_top)));
    endtask

    task automatic random_query();
        logic [31:0] epoch;
        int          sel;
        sel = $urandom_range(0, 19);
        if (sel == 0)
            epoch = '0;
        else if (sel == 1)
            epoch = '1;
        else if (sel < 4)
            epoch = $urandom;
        else
            epoch = epoch_base + $urandom_range(0, 8000);
        send_query(4'($urandom_range(0, type_top)), epoch, 3'($urandom_range(0, 7)),
                   pick_minute());
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. An empty table answers the default mode.
        send_query(4'd0, 32'd0, 3'd0, 11'd0);
        // Absolute window with inclusive bounds on both ends.
        send_window(5'd0, 4'd0, 4'd3, KIND_ABSOLUTE, 8'h00, 32'd100, 32'd200, 8'd10);
        send_query(4'd0, 32'd100, 3'd3, 11'd700);
        send_query(4'd0, 32'd200, 3'd3, 11'd700);
        send_query(4'd0, 32'd201, 3'd3, 11'd700);
        // Daily window wrapping past midnight, same priority: the lower mode wins.
        send_window(5'd31, 4'd0, 4'd1, KIND_DAILY, 8'h00, 32'd1380, 32'd60, 8'd10);
        send_query(4'd0, 32'd150, 3'd2, 11'd30);
        send_query(4'd0, 32'd150, 3'd2, 11'd700);
        // Monday-only window on the top type and mode, equal bounds cover the day.
        send_window(5'd5, 4'd15, 4'd15, KIND_DAY, 8'h01, 32'd500, 32'd500, 8'd255);
        send_query(4'd15, 32'd0, 3'd1, 11'd0);
        send_query(4'd15, 32'd0, 3'd0, 11'd0);
        send_query(4'd15, 32'd0, 3'd7, 11'd1439);
        // Odd-minute window overrides the day bits, even for weekday seven and a
        // minute past the end of the day.
        send_window(5'd6, 4'd15, 4'd0, KIND_DAY, 8'h80, 32'd0, 32'hFFFF_FFFF, 8'd255);
        send_query(4'd15, 32'hFFFF_FFFF, 3'd7, 11'd2047);
        send_query(4'd15, 32'd0, 3'd1, 11'd2046);
        // Sunday maps to mask bit 6; priority zero still beats the default.
        send_window(5'd7, 4'd2, 4'd7, KIND_DAY, 8'h40, 32'd0, 32'd1439, 8'd0);
        send_query(4'd2, 32'd0, 3'd0, 11'd1439);
        send_query(4'd2, 32'd0, 3'd6, 11'd0);
        // Emptying a slot removes its window.
        send_window(5'd0, 4'd0, 4'd3, KIND_EMPTY, 8'hFF, 32'd0, 32'd0, 8'd255);
        send_query(4'd0, 32'd150, 3'd2, 11'd700);
        // Full epoch range, then a tie against a whole-day daily window.
        send_window(5'd12, 4'd9, 4'd9, KIND_ABSOLUTE, 8'h00, 32'd0, 32'hFFFF_FFFF, 8'd128);
        send_query(4'd9, 32'hFFFF_FFFF, 3'd5, 11'd1000);
        send_window(5'd13, 4'd9, 4'd2, KIND_DAILY, 8'hFF, 32'd1439, 32'd1439, 8'd128);
        send_query(4'd9, 32'd0, 3'd4, 11'd1440);

        // Random part, in phases with different type spreads, priority spreads
        // and epoch bases. Narrow types and priorities make hits and ties common.
        for (int n = 0; n < 1750; n++) begin
            if (n % 250 == 0) begin
                case ($urandom_range(0, 2))
                    0:       type_top = 1;
                    1:       type_top = 3;
                    default: type_top = 15;
                endcase
                prio_top   = ($urandom_range(0, 1) == 0) ? 3 : 255;
                epoch_base = $urandom;
            end
            if ($urandom_range(0, 9) < 4)
                random_write();
            else
                random_query();
        end
        s_axis_tvalid <= 1'b0;
        // Let the checker register the last accepted word before counting.
        @(posedge i_clk);

        // Drain the outstanding answers, then give the block time to show any
        // stray word.
        while (results_due != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("time_window_mode_selector_tb: clean");
        end else begin
            $display("time_window_mode_selector_tb: errors");
        end
        $finish;
    end

endmodule

/* files.f */
src/twms_pkg.sv
src/twms_ram.sv
src/twms_match.sv
src/twms_seq.sv
src/time_window_mode_selector.sv
bench/mode_select_checker.sv
bench/time_window_mode_selector_tb.sv
